FILE: hdl/qgs_pkg.sv
// ----------------------------------------------------------------------------
// qgs_pkg: shared types and constants for the QAM Gray slicer
// Holds register indexes, fixed field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package qgs_pkg;

  // Fixed widths of the configuration registers and of the result fields.
  localparam int BITS_W    = 3;
  localparam int WEIGHT_W  = 15;
  localparam int NUM_WEIGHTS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int SYMBOL_W  = 12;
  localparam int PHASE_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_PHASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_QUADRATURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WEIGHT_0  = 3'd2;

  // Static control of one slicer cell: which axes decide here and the weight.
  typedef struct packed {
    logic                act_i;
    logic                act_q;
    logic [WEIGHT_W-1:0] weight;
  } cell_ctrl_t;

endpackage

FILE: hdl/qgs_cell.sv
// ----------------------------------------------------------------------------
// qgs_cell: one successive-approximation decision for both axes
// Compares each enabled axis value against zero, shifts the decision into
// the axis index and moves the value by the cell's level weight.
// ----------------------------------------------------------------------------
module qgs_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int VALUE_WIDTH  = 20,
  parameter int AXIS_BITS    = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qgs_pkg::cell_ctrl_t            ctrl,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_xi,
  input  logic signed [SAMPLE_WIDTH-1:0] in_xq,
  input  logic signed [VALUE_WIDTH-1:0]  in_vi,
  input  logic signed [VALUE_WIDTH-1:0]  in_vq,
  input  logic [AXIS_BITS-1:0]           in_si,
  input  logic [AXIS_BITS-1:0]           in_sq,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_xi,
  output logic signed [SAMPLE_WIDTH-1:0] out_xq,
  output logic signed [VALUE_WIDTH-1:0]  out_vi,
  output logic signed [VALUE_WIDTH-1:0]  out_vq,
  output logic [AXIS_BITS-1:0]           out_si,
  output logic [AXIS_BITS-1:0]           out_sq
);

  logic                          advance;
  logic signed [VALUE_WIDTH-1:0] wext;
  logic                          pos_i;
  logic                          pos_q;
  logic signed [VALUE_WIDTH-1:0] vi_next;
  logic signed [VALUE_WIDTH-1:0] vq_next;
  logic [AXIS_BITS-1:0]          si_next;
  logic [AXIS_BITS-1:0]          sq_next;

  // The stage moves whenever it is empty or its item leaves this cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  assign wext  = signed'(VALUE_WIDTH'(ctrl.weight));
  // Exactly zero counts as not above zero.
  assign pos_i = !in_vi[VALUE_WIDTH-1] && (in_vi != '0);
  assign pos_q = !in_vq[VALUE_WIDTH-1] && (in_vq != '0);

  always_comb begin
    vi_next = in_vi;
    si_next = in_si;
    if (ctrl.act_i) begin
      si_next = AXIS_BITS'({in_si, pos_i});
      vi_next = pos_i ? (in_vi - wext) : (in_vi + wext);
    end
    vq_next = in_vq;
    sq_next = in_sq;
    if (ctrl.act_q) begin
      sq_next = AXIS_BITS'({in_sq, pos_q});
      vq_next = pos_q ? (in_vq - wext) : (in_vq + wext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_xi <= in_xi;
      out_xq <= in_xq;
      out_vi <= vi_next;
      out_vq <= vq_next;
      out_si <= si_next;
      out_sq <= sq_next;
    end
  end

  a_idle_axis_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && !ctrl.act_i |=> out_vi == $past(in_vi) && out_si == $past(in_si))
    else $error("inactive I decision changed the axis value");

  a_decision_bit: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && ctrl.act_q |=> out_sq[0] == $past(pos_q))
    else $error("Q decision bit does not match the sign of the value");

endmodule

FILE: hdl/qgs_finish.sv
// ----------------------------------------------------------------------------
// qgs_finish: symbol packing, saturation and phase error
// Three registered stages: Gray coding and saturation, the two products,
// then the difference saturated to 32 bits into the output register.
// ----------------------------------------------------------------------------
module qgs_finish #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int VALUE_WIDTH  = 20,
  parameter int AXIS_BITS    = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [qgs_pkg::BITS_W-1:0]             mq,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_xi,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_xq,
  input  logic signed [VALUE_WIDTH-1:0]          in_vi,
  input  logic signed [VALUE_WIDTH-1:0]          in_vq,
  input  logic [AXIS_BITS-1:0]                   in_si,
  input  logic [AXIS_BITS-1:0]                   in_sq,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [qgs_pkg::SYMBOL_W-1:0]           symbol,
  output logic signed [SAMPLE_WIDTH-1:0]         resid_i,
  output logic signed [SAMPLE_WIDTH-1:0]         resid_q,
  output logic signed [SAMPLE_WIDTH-1:0]         est_i,
  output logic signed [SAMPLE_WIDTH-1:0]         est_q,
  output logic signed [qgs_pkg::PHASE_W-1:0]     phase_err
);

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int DIFF_W = (PROD_W + 1 > qgs_pkg::PHASE_W + 1) ? PROD_W + 1
                                                              : qgs_pkg::PHASE_W + 1;
  localparam logic signed [VALUE_WIDTH-1:0] SMAX =
    {{(VALUE_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] SMIN = ~SMAX;
  localparam logic signed [DIFF_W-1:0] PMAX =
    {{(DIFF_W - qgs_pkg::PHASE_W + 1){1'b0}}, {(qgs_pkg::PHASE_W - 1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] PMIN = ~PMAX;

  // Stage A: symbol, residuals, re-modulated point.
  logic                                adv_a;
  logic                                valid_a;
  logic [qgs_pkg::SYMBOL_W-1:0]        sym_a;
  logic signed [SAMPLE_WIDTH-1:0]      xi_a;
  logic signed [SAMPLE_WIDTH-1:0]      xq_a;
  logic signed [SAMPLE_WIDTH-1:0]      ri_a;
  logic signed [SAMPLE_WIDTH-1:0]      rq_a;
  logic signed [SAMPLE_WIDTH-1:0]      ei_a;
  logic signed [SAMPLE_WIDTH-1:0]      eq_a;
  // Stage B: products.
  logic                                adv_b;
  logic                                valid_b;
  logic [qgs_pkg::SYMBOL_W-1:0]        sym_b;
  logic signed [SAMPLE_WIDTH-1:0]      ri_b;
  logic signed [SAMPLE_WIDTH-1:0]      rq_b;
  logic signed [SAMPLE_WIDTH-1:0]      ei_b;
  logic signed [SAMPLE_WIDTH-1:0]      eq_b;
  logic signed [PROD_W-1:0]            pq_b;
  logic signed [PROD_W-1:0]            pi_b;
  // Output stage.
  logic                                adv_c;

  logic [AXIS_BITS-1:0]                gi;
  logic [AXIS_BITS-1:0]                gq;
  logic signed [VALUE_WIDTH-1:0]       ei_raw;
  logic signed [VALUE_WIDTH-1:0]       eq_raw;
  logic signed [DIFF_W-1:0]            diff;

  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !valid_b || adv_c;
  assign adv_a    = !valid_a || adv_b;
  assign in_ready = adv_a;

  assign gi     = in_si ^ (in_si >> 1);
  assign gq     = in_sq ^ (in_sq >> 1);
  // The re-modulated point is the input minus the unsaturated residual.
  assign ei_raw = VALUE_WIDTH'(in_xi) - in_vi;
  assign eq_raw = VALUE_WIDTH'(in_xq) - in_vq;
  assign diff   = DIFF_W'(pq_b) - DIFF_W'(pi_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) valid_a <= in_valid;
      if (adv_b) valid_b <= valid_a;
      if (adv_c) out_valid <= valid_b;
    end
    if (adv_a) begin
      sym_a <= (qgs_pkg::SYMBOL_W'(gi) << mq) + qgs_pkg::SYMBOL_W'(gq);
      xi_a  <= in_xi;
      xq_a  <= in_xq;
      ri_a  <= (in_vi > SMAX) ? SMAX[SAMPLE_WIDTH-1:0] :
               (in_vi < SMIN) ? SMIN[SAMPLE_WIDTH-1:0] : in_vi[SAMPLE_WIDTH-1:0];
      rq_a  <= (in_vq > SMAX) ? SMAX[SAMPLE_WIDTH-1:0] :
               (in_vq < SMIN) ? SMIN[SAMPLE_WIDTH-1:0] : in_vq[SAMPLE_WIDTH-1:0];
      ei_a  <= (ei_raw > SMAX) ? SMAX[SAMPLE_WIDTH-1:0] :
               (ei_raw < SMIN) ? SMIN[SAMPLE_WIDTH-1:0] : ei_raw[SAMPLE_WIDTH-1:0];
      eq_a  <= (eq_raw > SMAX) ? SMAX[SAMPLE_WIDTH-1:0] :
               (eq_raw < SMIN) ? SMIN[SAMPLE_WIDTH-1:0] : eq_raw[SAMPLE_WIDTH-1:0];
    end
    if (adv_b) begin
      sym_b <= sym_a;
      ri_b  <= ri_a;
      rq_b  <= rq_a;
      ei_b  <= ei_a;
      eq_b  <= eq_a;
      pq_b  <= PROD_W'(xq_a) * PROD_W'(ei_a);
      pi_b  <= PROD_W'(xi_a) * PROD_W'(eq_a);
    end
    if (adv_c) begin
      symbol    <= sym_b;
      resid_i   <= ri_b;
      resid_q   <= rq_b;
      est_i     <= ei_b;
      est_q     <= eq_b;
      phase_err <= (diff > PMAX) ? PMAX[qgs_pkg::PHASE_W-1:0] :
                   (diff < PMIN) ? PMIN[qgs_pkg::PHASE_W-1:0] :
                   diff[qgs_pkg::PHASE_W-1:0];
    end
  end

  a_product_stage: assert property (@(posedge clk) disable iff (rst)
    valid_a && adv_b |=> pq_b == PROD_W'($past(xq_a)) * PROD_W'($past(ei_a)))
    else $error("registered product does not match its operands");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    valid_b && adv_c |=> out_valid && symbol == $past(sym_b))
    else $error("item lost between product stage and output");

endmodule

FILE: hdl/qam_gray_slicer.sv
// ----------------------------------------------------------------------------
// qam_gray_slicer: hard-decision Gray demapper for rectangular QAM
// Slices I and Q by successive approximation and reports symbol, residuals,
// re-modulated point and phase error.
// ----------------------------------------------------------------------------
// The block takes one sample every clock cycle while the output is not stalled
// and returns one result per sample. A row of MAX_AXIS_BITS cells makes one
// decision per axis each, most significant first; cells above the configured
// bit count pass the item untouched. Three more stages form the symbol,
// saturate the residuals and the re-modulated point, multiply, and saturate
// the phase error. Every stage holds its item only while the one after it is
// full, so empty stages close up behind a stalled output. Write the
// configuration registers only while no item is in flight.
// ----------------------------------------------------------------------------
module qam_gray_slicer #(
  parameter int MAX_AXIS_BITS = 6,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qgs_pkg::WEIGHT_W-1:0]        cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // in_i, in_q
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // symbol, resid_i, resid_q, est_i, est_q, phase_err
  output logic [((4*SAMPLE_WIDTH+qgs_pkg::SYMBOL_W+qgs_pkg::PHASE_W+7)/8)*8-1:0]
                                              m_axis_tdata
);

  localparam int VALUE_WIDTH = ((SAMPLE_WIDTH > 19) ? SAMPLE_WIDTH : 19) + 1;
  localparam int OUT_W = ((4*SAMPLE_WIDTH+qgs_pkg::SYMBOL_W+qgs_pkg::PHASE_W+7)/8)*8;
  localparam logic [qgs_pkg::BITS_W-1:0] BITS_MAX = qgs_pkg::BITS_W'(MAX_AXIS_BITS);

  logic [qgs_pkg::BITS_W-1:0]   bits_in_phase;
  logic [qgs_pkg::BITS_W-1:0]   bits_quadrature;
  logic [qgs_pkg::WEIGHT_W-1:0] level_weight [qgs_pkg::NUM_WEIGHTS];
  logic [qgs_pkg::BITS_W-1:0]   mi;
  logic [qgs_pkg::BITS_W-1:0]   mq;

  logic                          c_valid [MAX_AXIS_BITS+1];
  logic                          c_ready [MAX_AXIS_BITS+1];
  logic signed [SAMPLE_WIDTH-1:0] c_xi   [MAX_AXIS_BITS+1];
  logic signed [SAMPLE_WIDTH-1:0] c_xq   [MAX_AXIS_BITS+1];
  logic signed [VALUE_WIDTH-1:0]  c_vi   [MAX_AXIS_BITS+1];
  logic signed [VALUE_WIDTH-1:0]  c_vq   [MAX_AXIS_BITS+1];
  logic [MAX_AXIS_BITS-1:0]       c_si   [MAX_AXIS_BITS+1];
  logic [MAX_AXIS_BITS-1:0]       c_sq   [MAX_AXIS_BITS+1];

  logic [qgs_pkg::SYMBOL_W-1:0]     symbol;
  logic signed [SAMPLE_WIDTH-1:0]   resid_i;
  logic signed [SAMPLE_WIDTH-1:0]   resid_q;
  logic signed [SAMPLE_WIDTH-1:0]   est_i;
  logic signed [SAMPLE_WIDTH-1:0]   est_q;
  logic signed [qgs_pkg::PHASE_W-1:0] phase_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_phase   <= qgs_pkg::BITS_W'(2);
      bits_quadrature <= qgs_pkg::BITS_W'(2);
      level_weight[0] <= qgs_pkg::WEIGHT_W'(2896);
      level_weight[1] <= qgs_pkg::WEIGHT_W'(5793);
      level_weight[2] <= qgs_pkg::WEIGHT_W'(11585);
      level_weight[3] <= qgs_pkg::WEIGHT_W'(23170);
      level_weight[4] <= '0;
      level_weight[5] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qgs_pkg::REG_BITS_IN_PHASE:   bits_in_phase   <= cfg_data[qgs_pkg::BITS_W-1:0];
        qgs_pkg::REG_BITS_QUADRATURE: bits_quadrature <= cfg_data[qgs_pkg::BITS_W-1:0];
        default: begin
          level_weight[cfg_index - qgs_pkg::REG_LEVEL_WEIGHT_0] <= cfg_data;
        end
      endcase
    end
  end

  // Bit counts above the cell count saturate to it.
  assign mi = (bits_in_phase > BITS_MAX) ? BITS_MAX : bits_in_phase;
  assign mq = (bits_quadrature > BITS_MAX) ? BITS_MAX : bits_quadrature;

  assign c_valid[0]    = s_axis_tvalid;
  assign s_axis_tready = c_ready[0];
  assign c_xi[0] = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign c_xq[0] = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign c_vi[0] = VALUE_WIDTH'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  assign c_vq[0] = VALUE_WIDTH'(signed'(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
  assign c_si[0] = '0;
  assign c_sq[0] = '0;

  // Cell c applies weight MAX_AXIS_BITS-1-c, and only when that weight is
  // within the axis bit count, so the leading cells idle for small counts.
  for (genvar c = 0; c < MAX_AXIS_BITS; c++) begin : g_cell
    qgs_pkg::cell_ctrl_t ctrl;
    assign ctrl.act_i  = qgs_pkg::BITS_W'(MAX_AXIS_BITS - 1 - c) < mi;
    assign ctrl.act_q  = qgs_pkg::BITS_W'(MAX_AXIS_BITS - 1 - c) < mq;
    assign ctrl.weight = level_weight[MAX_AXIS_BITS - 1 - c];

    qgs_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .VALUE_WIDTH  (VALUE_WIDTH),
      .AXIS_BITS    (MAX_AXIS_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .in_valid  (c_valid[c]),
      .in_ready  (c_ready[c]),
      .in_xi     (c_xi[c]),
      .in_xq     (c_xq[c]),
      .in_vi     (c_vi[c]),
      .in_vq     (c_vq[c]),
      .in_si     (c_si[c]),
      .in_sq     (c_sq[c]),
      .out_valid (c_valid[c+1]),
      .out_ready (c_ready[c+1]),
      .out_xi    (c_xi[c+1]),
      .out_xq    (c_xq[c+1]),
      .out_vi    (c_vi[c+1]),
      .out_vq    (c_vq[c+1]),
      .out_si    (c_si[c+1]),
      .out_sq    (c_sq[c+1])
    );
  end

  qgs_finish #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .AXIS_BITS    (MAX_AXIS_BITS)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .mq        (mq),
    .in_valid  (c_valid[MAX_AXIS_BITS]),
    .in_ready  (c_ready[MAX_AXIS_BITS]),
    .in_xi     (c_xi[MAX_AXIS_BITS]),
    .in_xq     (c_xq[MAX_AXIS_BITS]),
    .in_vi     (c_vi[MAX_AXIS_BITS]),
    .in_vq     (c_vq[MAX_AXIS_BITS]),
    .in_si     (c_si[MAX_AXIS_BITS]),
    .in_sq     (c_sq[MAX_AXIS_BITS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .symbol    (symbol),
    .resid_i   (resid_i),
    .resid_q   (resid_q),
    .est_i     (est_i),
    .est_q     (est_q),
    .phase_err (phase_err)
  );

  assign m_axis_tdata = OUT_W'({phase_err, est_q, est_i, resid_q, resid_i, symbol});

  a_bits_clamped: assert property (@(posedge clk) disable iff (rst)
    mi <= BITS_MAX && mq <= BITS_MAX)
    else $error("axis bit count exceeds the cell count");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the QAM Gray slicer
// Drives complex samples over the input stream and checks every result
// against a cycle-free predictor of the slicer. Directed tests cover the reset
// settings, the axis bit count limits and zero weights. A long random test
// then steps through many register settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int AXIS_MAX  = 6;
  localparam int SAMPLE_W  = 16;
  localparam int LATENCY   = AXIS_MAX + 3;
  localparam int IDLE_LIMIT = 5000;
  localparam int OUT_W     = ((4*SAMPLE_W + qgs_pkg::SYMBOL_W + qgs_pkg::PHASE_W + 7)/8)*8;

  localparam longint SMAX = 64'sd32767;
  localparam longint SMIN = -64'sd32768;
  localparam longint PMAX = 64'sd2147483647;
  localparam longint PMIN = -64'sd2147483648;

  typedef logic [qgs_pkg::WEIGHT_W-1:0] weight_set_t [qgs_pkg::NUM_WEIGHTS];

  typedef struct {
    logic [qgs_pkg::SYMBOL_W-1:0]       symbol;
    logic signed [SAMPLE_W-1:0]         resid_i;
    logic signed [SAMPLE_W-1:0]         resid_q;
    logic signed [SAMPLE_W-1:0]         est_i;
    logic signed [SAMPLE_W-1:0]         est_q;
    logic signed [qgs_pkg::PHASE_W-1:0] phase_err;
  } slice_result_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [qgs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qgs_pkg::WEIGHT_W-1:0]   cfg_data;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  logic [OUT_W-1:0]               m_axis_tdata;

  // Register mirror used by the predictor.
  logic [qgs_pkg::BITS_W-1:0]     bits_i_cfg;
  logic [qgs_pkg::BITS_W-1:0]     bits_q_cfg;
  logic [qgs_pkg::WEIGHT_W-1:0]   weight_cfg [qgs_pkg::NUM_WEIGHTS];

  slice_result_t         pending_slices [$];
  int                    error_count = 0;
  int                    burst_left = 0;
  int                    idle_cycles = 0;
  rx_mode_t              rx_mode = RX_FREE;
  int unsigned           rx_left = 0;
  int unsigned           rx_tick = 0;

  qam_gray_slicer #(
    .MAX_AXIS_BITS(AXIS_MAX),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Successive approximation on one axis; returns the binary index.
  function automatic int unsigned slice_axis(input longint start, input int unsigned m,
                                             output longint res);
    longint      v;
    int unsigned s;
    int unsigned k;
    v = start;
    s = 0;
    for (int unsigned n = 0; n < m; n++) begin
      k = m - 1 - n;
      s = s << 1;
      if (v > 0) begin
        s = s | 1;
        v = v - longint'(weight_cfg[k]);
      end else begin
        v = v + longint'(weight_cfg[k]);
      end
    end
    res = v;
    return s;
  endfunction

  function automatic slice_result_t predict_slice(input logic signed [SAMPLE_W-1:0] xi_in,
                                                  input logic signed [SAMPLE_W-1:0] xq_in);
    slice_result_t r;
    longint        xi, xq, ri, rq, ei, eq;
    int unsigned   mi, mq, si, sq, sym;
    xi = longint'(xi_in);
    xq = longint'(xq_in);
    mi = (bits_i_cfg > AXIS_MAX) ? AXIS_MAX : bits_i_cfg;
    mq = (bits_q_cfg > AXIS_MAX) ? AXIS_MAX : bits_q_cfg;
    si = slice_axis(xi, mi, ri);
    sq = slice_axis(xq, mq, rq);
    si = si ^ (si >> 1);
    sq = sq ^ (sq >> 1);
    sym = (si << mq) + sq;
    ei = saturate(xi - ri, SMIN, SMAX);
    eq = saturate(xq - rq, SMIN, SMAX);
    r.symbol    = sym[qgs_pkg::SYMBOL_W-1:0];
    r.resid_i   = SAMPLE_W'(saturate(ri, SMIN, SMAX));
    r.resid_q   = SAMPLE_W'(saturate(rq, SMIN, SMAX));
    r.est_i     = SAMPLE_W'(ei);
    r.est_q     = SAMPLE_W'(eq);
    r.phase_err = qgs_pkg::PHASE_W'(saturate(xq * ei - xi * eq, PMIN, PMAX));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    slice_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_slices.size() == 0) begin
        error_count++;
        $error("result with no sample pending: tdata %h", m_axis_tdata);
      end else begin
        want = pending_slices.pop_front();
        check_field("symbol", 64'(want.symbol), 64'(m_axis_tdata[11:0]));
        check_field("resid_i", 64'(want.resid_i), 64'($signed(m_axis_tdata[27:12])));
        check_field("resid_q", 64'(want.resid_q), 64'($signed(m_axis_tdata[43:28])));
        check_field("est_i", 64'(want.est_i), 64'($signed(m_axis_tdata[59:44])));
        check_field("est_q", 64'(want.est_q), 64'($signed(m_axis_tdata[75:60])));
        check_field("phase_err", 64'(want.phase_err), 64'($signed(m_axis_tdata[107:76])));
      end
    end
  end

  // Output back-pressure: a random pattern that is redrawn whenever its countdown runs out.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_FREE:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (rx_tick[1:0] == 2'd0);
      default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [qgs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [qgs_pkg::WEIGHT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == qgs_pkg::REG_BITS_IN_PHASE)
      bits_i_cfg = value[qgs_pkg::BITS_W-1:0];
    else if (idx == qgs_pkg::REG_BITS_QUADRATURE)
      bits_q_cfg = value[qgs_pkg::BITS_W-1:0];
    else if (idx >= qgs_pkg::REG_LEVEL_WEIGHT_0 &&
             idx < qgs_pkg::REG_LEVEL_WEIGHT_0 + qgs_pkg::NUM_WEIGHTS)
      weight_cfg[idx - qgs_pkg::REG_LEVEL_WEIGHT_0] = value;
  endtask

  task automatic program_slicer(input logic [qgs_pkg::WEIGHT_W-1:0] bits_i,
                                input logic [qgs_pkg::WEIGHT_W-1:0] bits_q,
                                input weight_set_t w);
    write_register(qgs_pkg::REG_BITS_IN_PHASE, bits_i);
    write_register(qgs_pkg::REG_BITS_QUADRATURE, bits_q);
    for (int k = 0; k < qgs_pkg::NUM_WEIGHTS; k++)
      write_register(qgs_pkg::CFG_IDX_W'(qgs_pkg::REG_LEVEL_WEIGHT_0 + k), w[k]);
  endtask

  // Sends one item; the sender works in bursts with random gaps between them.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] xi,
                             input logic signed [SAMPLE_W-1:0] xq);
    int gap;
    s_axis_tdata  <= {xq, xi};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_slices.push_back(predict_slice(xi, xq));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops the stream and waits until every result is back and the pipe is empty.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // One axis value: uniform, near a decision threshold, near a point, or extreme.
  function automatic logic signed [SAMPLE_W-1:0] pick_axis_value(
      input logic [qgs_pkg::BITS_W-1:0] m);
    int unsigned mm, sel, stop;
    longint      v;
    mm  = (m > AXIS_MAX) ? AXIS_MAX : m;
    sel = $urandom_range(0, 99);
    v   = 0;
    if (sel < 50) begin
      v = longint'($signed(16'($urandom)));
    end else if (sel < 90) begin
      stop = (sel < 75 && mm > 0) ? $urandom_range(0, mm - 1) : 0;
      for (int k = AXIS_MAX - 1; k >= 0; k--)
        if (k < mm && k >= stop)
          v = $urandom_range(0, 1) ? v + weight_cfg[k] : v - weight_cfg[k];
      if (sel < 75)
        v = v + $urandom_range(0, 2) - 1;
      else
        v = v + $urandom_range(0, 1024) - 512;
    end else begin
      case ($urandom_range(0, 4))
        0: v = SMIN;
        1: v = SMAX;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end
    return SAMPLE_W'(saturate(v, SMIN, SMAX));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_settings();
    // Two bits per axis with the reset weights; 5793 lands on exact zero.
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sd5793, -16'sd5793);
    send_sample(16'sd8689, 16'sd2896);
    drain_pipeline();
  endtask

  task automatic test_axis_bit_limits();
    weight_set_t w;
    for (int k = 0; k < qgs_pkg::NUM_WEIGHTS; k++) w[k] = 15'h7FFF;
    // A count of seven saturates to six; upper data bits are dropped.
    program_slicer(15'h7FFF, 15'h0000, w);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd12345);
    send_sample(16'sd100, -16'sd100);
    drain_pipeline();
    program_slicer(15'h7FF8, 15'h7FFE, w);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0);
    drain_pipeline();
  endtask

  task automatic test_zero_weights();
    weight_set_t w;
    for (int k = 0; k < qgs_pkg::NUM_WEIGHTS; k++) w[k] = '0;
    program_slicer(15'd3, 15'd5, w);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd5, -16'sd5);
    send_sample(-16'sd1, 16'sd1);
    drain_pipeline();
  endtask

  task automatic test_random_settings();
    weight_set_t w;
    logic [qgs_pkg::WEIGHT_W-1:0] bits_i, bits_q;
    int unsigned base, count;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       begin bits_i = 15'd6; bits_q = 15'd6; end
        1:       begin bits_i = 15'd1; bits_q = 15'd1; end
        2:       begin bits_i = 15'd0; bits_q = 15'd6; end
        3:       begin bits_i = 15'd7; bits_q = 15'd3; end
        default: begin
          bits_i = qgs_pkg::WEIGHT_W'($urandom_range(1, 6));
          bits_q = qgs_pkg::WEIGHT_W'($urandom_range(1, 6));
        end
      endcase
      base = $urandom_range(256, 4096);
      for (int k = 0; k < qgs_pkg::NUM_WEIGHTS; k++) begin
        case (p % 4)
          0: w[k] = (p == 0) ? 15'h7FFF : 15'($urandom);
          1: w[k] = ((base << k) > 32767) ? 15'h7FFF : 15'(base << k);
          2: w[k] = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
          default: w[k] = ((base << k) > 32767) ? 15'($urandom) : 15'(base << k);
        endcase
      end
      program_slicer(bits_i, bits_q, w);
      count = $urandom_range(95, 125);
      for (int n = 0; n < count; n++)
        send_sample(pick_axis_value(bits_i_cfg), pick_axis_value(bits_q_cfg));
      drain_pipeline();
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    bits_i_cfg    = qgs_pkg::BITS_W'(2);
    bits_q_cfg    = qgs_pkg::BITS_W'(2);
    weight_cfg    = '{15'd2896, 15'd5793, 15'd11585, 15'd23170, 15'd0, 15'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_axis_bit_limits();
    test_zero_weights();
    test_random_settings();

    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
